// ===== design/sbo_pkg.sv =====
package sbo_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int MIN_WIDTH = 256;
    localparam int MAX_BARS  = 128;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = COL_W + 1;
    localparam int POS_W  = COL_W + 9;
    localparam int Q_W    = COL_W - 1;
    localparam int DSH_W  = POS_W + Q_W;
    localparam int STEP_W = $clog2(Q_W + 1);
    localparam int COV_W  = 9;

    localparam int CFG_W = 12;
    localparam int IDX_W = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [11:0] RST_LINE_WIDTH = 12'd720;
    localparam logic [7:0]  RST_BAR_ALPHA  = 8'd255;
    localparam logic [7:0]  RST_BAR_LUMA   = 8'd235;
    localparam logic [7:0]  RST_BAR_CB     = 8'd128;
    localparam logic [7:0]  RST_BAR_CR     = 8'd128;
    localparam logic [7:0]  RST_BARS_DRAWN = 8'd0;

    typedef enum logic [IDX_W-1:0] {
        REG_LINE_WIDTH = 3'd0,
        REG_BAR_ALPHA  = 3'd1,
        REG_BAR_LUMA   = 3'd2,
        REG_BAR_CB     = 3'd3,
        REG_BAR_CR     = 3'd4,
        REG_BARS_DRAWN = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] line_width;
        logic [7:0]  bar_alpha;
        logic [7:0]  bar_luma;
        logic [7:0]  bar_cb;
        logic [7:0]  bar_cr;
        logic [7:0]  bars_drawn;
    } cfg_t;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] y;
        logic [7:0] cb;
        logic [7:0] cr;
    } pix_t;

    typedef struct packed {
        pix_t             bg;
        logic [COV_W-1:0] cov;
    } item_t;

endpackage

// ===== design/sbo_front.sv =====
module sbo_front (
    input  logic          clk,
    input  logic          rst_n,
    input  sbo_pkg::cfg_t cfg,
    input  logic          width_wr,
    input  logic          push,
    input  sbo_pkg::pix_t bg,
    input  logic          line_start,
    output logic          full,
    output logic          q_push,
    output sbo_pkg::item_t q_item,
    input  logic          q_full
);

    logic [sbo_pkg::WID_W-1:0]  w;
    logic [sbo_pkg::WID_W:0]    w2;

    logic [sbo_pkg::COL_W-1:0]  col_reg;
    logic [sbo_pkg::Q_W-1:0]    q_reg;
    logic [sbo_pkg::POS_W-1:0]  bstart_reg;
    logic [sbo_pkg::POS_W-1:0]  bnd_reg;

    logic                       start_reg;
    logic                       busy_reg;
    logic [sbo_pkg::STEP_W-1:0] step_reg;
    logic [sbo_pkg::POS_W-1:0]  rem_reg;
    logic [sbo_pkg::DSH_W-1:0]  dsh_reg;
    logic [sbo_pkg::Q_W-1:0]    qacc_reg;

    logic [sbo_pkg::POS_W-1:0]  rem_next;
    logic [sbo_pkg::Q_W-1:0]    qacc_next;
    logic [sbo_pkg::POS_W-1:0]  cur_pos;

    logic                       accept;
    logic [sbo_pkg::COL_W-1:0]  col;
    logic [sbo_pkg::Q_W-1:0]    q;
    logic [sbo_pkg::POS_W-1:0]  bstart;
    logic [sbo_pkg::POS_W-1:0]  bnd;
    logic [sbo_pkg::POS_W-1:0]  bend;
    logic [sbo_pkg::POS_W-1:0]  pix_lo;
    logic [sbo_pkg::POS_W-1:0]  pix_hi;
    logic [sbo_pkg::POS_W-1:0]  lo;
    logic [sbo_pkg::POS_W-1:0]  hi;
    logic [7:0]                 drawn;
    logic                       shown;

    logic [sbo_pkg::COL_W-1:0]  col_next;
    logic [sbo_pkg::POS_W-1:0]  pos_next;
    logic [sbo_pkg::Q_W-1:0]    q_next;
    logic [sbo_pkg::POS_W-1:0]  bstart_next;
    logic [sbo_pkg::POS_W-1:0]  bnd_next;

    always_comb
    begin
        if (cfg.line_width < 12'(sbo_pkg::MIN_WIDTH))
        begin
            w = sbo_pkg::WID_W'(sbo_pkg::MIN_WIDTH);
        end
        else if (32'(cfg.line_width) > sbo_pkg::MAX_WIDTH)
        begin
            w = sbo_pkg::WID_W'(sbo_pkg::MAX_WIDTH);
        end
        else
        begin
            w = sbo_pkg::WID_W'(cfg.line_width);
        end
    end

    assign w2 = {w, 1'b0};

    // The tracker keeps the bar that the stored column's last sub-pixel falls in,
    // and recomputes it by shift-subtract division whenever the width changes.
    assign cur_pos = sbo_pkg::POS_W'({col_reg, 8'hFF});

    always_comb
    begin
        if (sbo_pkg::DSH_W'(rem_reg) >= dsh_reg)
        begin
            rem_next  = rem_reg - dsh_reg[sbo_pkg::POS_W-1:0];
            qacc_next = {qacc_reg[sbo_pkg::Q_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_reg;
            qacc_next = {qacc_reg[sbo_pkg::Q_W-2:0], 1'b0};
        end
    end

    assign full   = start_reg || busy_reg || q_full;
    assign accept = push && !full;

    always_comb
    begin
        col    = line_start ? '0 : col_reg;
        q      = line_start ? '0 : q_reg;
        bstart = line_start ? '0 : bstart_reg;
        bnd    = line_start ? sbo_pkg::POS_W'(w2) : bnd_reg;

        pix_lo = sbo_pkg::POS_W'({col, 8'h00});
        pix_hi = pix_lo + sbo_pkg::POS_W'(256);
        bend   = bstart + sbo_pkg::POS_W'(w);
        lo     = (bstart > pix_lo) ? bstart : pix_lo;
        hi     = (bend < pix_hi) ? bend : pix_hi;
        drawn  = (cfg.bars_drawn > 8'(sbo_pkg::MAX_BARS)) ? 8'(sbo_pkg::MAX_BARS)
                                                           : cfg.bars_drawn;
        shown  = int'(q) < int'(drawn);

        q_item.bg  = bg;
        q_item.cov = (shown && hi > lo) ? sbo_pkg::COV_W'(hi - lo) : '0;

        if (32'(col) + 1 >= sbo_pkg::MAX_WIDTH)
        begin
            col_next = col;
        end
        else
        begin
            col_next = col + 1'b1;
        end
        pos_next = sbo_pkg::POS_W'({col_next, 8'hFF});
        if (pos_next >= bnd)
        begin
            q_next      = q + 1'b1;
            bstart_next = bnd;
            bnd_next    = bnd + sbo_pkg::POS_W'(w2);
        end
        else
        begin
            q_next      = q;
            bstart_next = bstart;
            bnd_next    = bnd;
        end
    end

    assign q_push = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            q_reg      <= '0;
            bstart_reg <= '0;
            bnd_reg    <= '0;
            start_reg  <= 1'b1;
            busy_reg   <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            if (width_wr)
            begin
                start_reg <= 1'b1;
                busy_reg  <= 1'b0;
            end
            else if (start_reg)
            begin
                start_reg <= 1'b0;
                busy_reg  <= 1'b1;
                step_reg  <= sbo_pkg::STEP_W'(sbo_pkg::Q_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    busy_reg   <= 1'b0;
                    q_reg      <= qacc_next;
                    bstart_reg <= cur_pos - rem_next;
                    bnd_reg    <= cur_pos - rem_next + sbo_pkg::POS_W'(w2);
                end
            end
            else if (accept)
            begin
                col_reg    <= col_next;
                q_reg      <= q_next;
                bstart_reg <= bstart_next;
                bnd_reg    <= bnd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_reg)
        begin
            rem_reg  <= cur_pos;
            dsh_reg  <= sbo_pkg::DSH_W'(w2) << (sbo_pkg::Q_W - 1);
            qacc_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            dsh_reg  <= dsh_reg >> 1;
            qacc_reg <= qacc_next;
        end
    end

endmodule

// ===== design/sbo_queue.sv =====
module sbo_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sbo_pkg::item_t wr_item,
    output logic           full,
    input  logic           pop,
    output sbo_pkg::item_t rd_item,
    output logic           empty
);

    sbo_pkg::item_t              mem_reg [sbo_pkg::QUEUE_DEPTH];
    logic [sbo_pkg::QPTR_W-1:0]  wptr_reg;
    logic [sbo_pkg::QPTR_W-1:0]  rptr_reg;
    logic [sbo_pkg::QPTR_W:0]    count_reg;
    logic                        do_push;
    logic                        do_pop;

    assign full    = count_reg == (sbo_pkg::QPTR_W + 1)'(sbo_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

// ===== design/sbo_back.sv =====
module sbo_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sbo_pkg::cfg_t  cfg,
    input  sbo_pkg::item_t q_item,
    input  logic           q_empty,
    output logic           q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     out_alpha,
    output logic [7:0]     out_luma,
    output logic [7:0]     out_cb,
    output logic [7:0]     out_cr,
    output logic           in_bar
);

    function automatic logic [7:0] blend(input logic [7:0] bgv, input logic [7:0] tgt,
                                         input logic [7:0] a);
        logic signed [9:0]  r;
        logic signed [18:0] t;
        logic signed [18:0] s;
        logic signed [9:0]  m;
        logic signed [9:0]  sum;
        r   = $signed({2'b00, tgt}) - $signed({2'b00, bgv});
        t   = r * $signed({1'b0, a}) + 19'sd128;
        s   = t + (t >>> 8);
        m   = 10'(s >>> 8);
        sum = $signed({2'b00, bgv}) + m;
        return sum[7:0];
    endfunction

    logic             s1_valid_reg;
    sbo_pkg::pix_t    s1_bg_reg;
    logic [7:0]       s1_alpha_reg;
    logic             s1_hit_reg;

    logic             out_valid_reg;
    sbo_pkg::pix_t    out_pix_reg;
    logic             out_hit_reg;

    logic             out_ready;
    logic             s1_ready;
    logic [15:0]      prod;
    logic [7:0]       alpha;
    sbo_pkg::pix_t    mixed;

    assign out_ready = !out_valid_reg || pop;
    assign s1_ready  = !s1_valid_reg || out_ready;
    assign q_pop     = !q_empty && s1_ready;

    assign prod  = q_item.cov[7:0] * cfg.bar_alpha;
    assign alpha = q_item.cov[8] ? cfg.bar_alpha : prod[15:8];

    always_comb
    begin
        if (s1_hit_reg)
        begin
            mixed.a  = blend(s1_bg_reg.a, s1_alpha_reg, s1_alpha_reg);
            mixed.y  = blend(s1_bg_reg.y, cfg.bar_luma, s1_alpha_reg);
            mixed.cb = blend(s1_bg_reg.cb, cfg.bar_cb, s1_alpha_reg);
            mixed.cr = blend(s1_bg_reg.cr, cfg.bar_cr, s1_alpha_reg);
        end
        else
        begin
            mixed = s1_bg_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= !q_empty;
            end
            if (out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_bg_reg    <= q_item.bg;
            s1_alpha_reg <= alpha;
            s1_hit_reg   <= q_item.cov != '0;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_pix_reg <= mixed;
            out_hit_reg <= s1_hit_reg;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_alpha = out_pix_reg.a;
    assign out_luma  = out_pix_reg.y;
    assign out_cb    = out_pix_reg.cb;
    assign out_cr    = out_pix_reg.cr;
    assign in_bar    = out_hit_reg;

endmodule

// ===== design/subpixel_bar_overlay_top.sv =====
// Sub-pixel bar overlay: pixels of a scanline enter through push/full and leave, composited with
// up to 128 anti-aliased bars, through empty/pop in the same order, one result per pixel. The
// block sustains one pixel per clock when results are popped and no tracker rebuild runs; a pixel
// passes through the queue, the s1 stage and the output register. After reset and every write
// of line_width, full stays high while the tracker finds the current bar with a shift-subtract
// divider that produces one quotient bit per cycle; no other configuration write stalls the input.
module subpixel_bar_overlay_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [sbo_pkg::IDX_W-1:0] cfg_index,
    input  logic [sbo_pkg::CFG_W-1:0] cfg_data,
    input  logic                      push,
    output logic                      full,
    input  logic [7:0]                bg_alpha,
    input  logic [7:0]                bg_luma,
    input  logic [7:0]                bg_cb,
    input  logic [7:0]                bg_cr,
    input  logic                      line_start,
    output logic                      empty,
    input  logic                      pop,
    output logic [7:0]                out_alpha,
    output logic [7:0]                out_luma,
    output logic [7:0]                out_cb,
    output logic [7:0]                out_cr,
    output logic                      in_bar
);

    sbo_pkg::cfg_t  cfg_reg;
    logic           width_wr;
    sbo_pkg::pix_t  bg;
    sbo_pkg::item_t wr_item;
    sbo_pkg::item_t rd_item;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           q_empty;

    assign width_wr = cfg_we && (cfg_index == sbo_pkg::REG_LINE_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_width <= sbo_pkg::RST_LINE_WIDTH;
            cfg_reg.bar_alpha  <= sbo_pkg::RST_BAR_ALPHA;
            cfg_reg.bar_luma   <= sbo_pkg::RST_BAR_LUMA;
            cfg_reg.bar_cb     <= sbo_pkg::RST_BAR_CB;
            cfg_reg.bar_cr     <= sbo_pkg::RST_BAR_CR;
            cfg_reg.bars_drawn <= sbo_pkg::RST_BARS_DRAWN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbo_pkg::REG_LINE_WIDTH: cfg_reg.line_width <= cfg_data;
                sbo_pkg::REG_BAR_ALPHA:  cfg_reg.bar_alpha  <= cfg_data[7:0];
                sbo_pkg::REG_BAR_LUMA:   cfg_reg.bar_luma   <= cfg_data[7:0];
                sbo_pkg::REG_BAR_CB:     cfg_reg.bar_cb     <= cfg_data[7:0];
                sbo_pkg::REG_BAR_CR:     cfg_reg.bar_cr     <= cfg_data[7:0];
                sbo_pkg::REG_BARS_DRAWN: cfg_reg.bars_drawn <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign bg.a  = bg_alpha;
    assign bg.y  = bg_luma;
    assign bg.cb = bg_cb;
    assign bg.cr = bg_cr;

    sbo_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .width_wr   (width_wr),
        .push       (push),
        .bg         (bg),
        .line_start (line_start),
        .full       (full),
        .q_push     (q_push),
        .q_item     (wr_item),
        .q_full     (q_full)
    );

    sbo_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_item (wr_item),
        .full    (q_full),
        .pop     (q_pop),
        .rd_item (rd_item),
        .empty   (q_empty)
    );

    sbo_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_item    (rd_item),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_alpha (out_alpha),
        .out_luma  (out_luma),
        .out_cb    (out_cb),
        .out_cr    (out_cr),
        .in_bar    (in_bar)
    );

endmodule

// ===== design/sbo_checker.sv =====
module sbo_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_we,
    input logic [sbo_pkg::IDX_W-1:0] cfg_index,
    input logic                      full,
    input logic                      empty,
    input logic                      pop,
    input logic [7:0]                out_alpha,
    input logic [7:0]                out_luma,
    input logic [7:0]                out_cb,
    input logic [7:0]                out_cr,
    input logic                      in_bar
);

    // The bar tracker must be rebuilt before the first pixel after reset.
    a_full_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> full)
        else $error("input accepted before the bar tracker was rebuilt after reset");

    // A new line width invalidates the tracker, so the input must close.
    a_full_after_width: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == sbo_pkg::REG_LINE_WIDTH |=> full)
        else $error("input open right after a line width write");

    // A waiting result holds until its transfer.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_alpha) && $stable(out_luma)
                           && $stable(out_cb) && $stable(out_cr) && $stable(in_bar))
        else $error("waiting result changed before its transfer");

endmodule

bind subpixel_bar_overlay_top sbo_checker u_sbo_checker (.*);
